>>> rtl/core/gba_pkg.sv
// Shared types, constants and helpers of the grid bin aggregator.
// Used by the controller, the datapath and the top level; no dependencies.
package gba_pkg;

   localparam int NUM_BINS = 1024;
   localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   localparam int CMD_W  = 2;
   localparam int BIN_W  = 10;
   localparam int VAL_W  = 64;
   localparam int MODE_W = 3;
   localparam int EXP_W  = 4;
   localparam int HALF_W = VAL_W / 2;

   // Stream payload layout: bin, value and order packed from bit 0, padded to bytes.
   localparam int FIELDS_W   = BIN_W + 2 * VAL_W;
   localparam int DATA_W     = ((FIELDS_W + 7) / 8) * 8;
   localparam int PAD_W      = DATA_W - FIELDS_W;
   localparam int REQ_USER_W = CMD_W + 1;
   localparam int RSP_USER_W = 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_AGG_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_EXP = 1'b1;

   localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAX   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POWER = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FIRST = 3'd5;

   localparam logic [VAL_W-1:0] S64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] S64_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // One memory word per bin: {used, first order key, accumulator}.
   localparam int MEM_W = 2 * VAL_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_MERGE  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // Steps of the shared 32x32 multiplier that builds one 64-bit product.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_LL,
      MUL_HL,
      MUL_LH,
      MUL_FINISH
   } mul_op_type;

   typedef struct packed {
      logic       load_item;
      logic       clr_step;
      logic       mem_rd;
      logic       mem_we;
      logic       out_load;
      mul_op_type mul_op;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic need_pow;
      logic exp_zero;
      logic exp_last;
   } dp_status_type;

   function automatic logic [VAL_W-1:0] identity_of(input logic [MODE_W-1:0] mode);
      logic [VAL_W-1:0] id;
      id = '0;
      if (mode == MODE_MIN) begin
         id = S64_MAX;
      end else if (mode == MODE_MAX) begin
         id = S64_MIN;
      end
      return id;
   endfunction

endpackage

>>> rtl/core/gba_ctrl.sv
// Controller state machine of the grid bin aggregator.
// Sequences clearing, bin read, power multiply steps and bin write; uses gba_pkg.
module gba_ctrl
   import gba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   input  dp_status_type status,
   output ctl_cmd_type   ctl_cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MULACC,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      ctl_cmd       = '0;
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         S_CLEAR: begin
            ctl_cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ctl_cmd.load_item = 1'b1;
               state_in          = S_READ;
            end
         end
         S_READ: begin
            ctl_cmd.mem_rd = 1'b1;
            state_in = (status.need_pow && !status.exp_zero) ? S_MUL0 : S_WRITE;
         end
         S_MUL0: begin
            ctl_cmd.mul_op = MUL_LL;
            state_in       = S_MUL1;
         end
         S_MUL1: begin
            ctl_cmd.mul_op = MUL_HL;
            state_in       = S_MUL2;
         end
         S_MUL2: begin
            ctl_cmd.mul_op = MUL_LH;
            state_in       = S_MULACC;
         end
         S_MULACC: begin
            ctl_cmd.mul_op = MUL_FINISH;
            state_in = status.exp_last ? S_WRITE : S_MUL0;
         end
         S_WRITE: begin
            // The result register must be free before the bin is committed.
            if (!rsp_tvalid_ff || rsp_tready) begin
               ctl_cmd.mem_we   = 1'b1;
               ctl_cmd.out_load = 1'b1;
               rsp_tvalid_in    = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

`ifndef SYNTHESIS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_READ))
      else $error("accepted transaction did not start a bin read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while a transaction waits");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.out_load |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

   a_mul_no_write: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.mul_op != MUL_NONE) |-> (!ctl_cmd.mem_we && !req_tready))
      else $error("bin write or accept during power multiply");
`endif

endmodule

>>> rtl/core/gba_datapath.sv
// Datapath of the grid bin aggregator: configuration, bin memory, power
// multiplier, fold logic and result register; uses gba_pkg.
module gba_datapath
   import gba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [DATA_W-1:0]     req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  ctl_cmd_type           ctl_cmd,
   output dp_status_type         status,
   output logic [DATA_W-1:0]     rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [MODE_W-1:0] mode_ff;
   logic [EXP_W-1:0]  exp_ff;
   logic [BIN_AW-1:0] clr_cnt_ff;
   logic [EXP_W-1:0]  exp_cnt_ff;

   cmd_type           cmd_ff;
   logic [BIN_W-1:0]  bin_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [VAL_W-1:0]  key_ff;
   logic              inc_ff;

   logic [VAL_W-1:0]  pow_ff;
   logic [VAL_W-1:0]  prod_ff;
   logic [VAL_W-1:0]  part_ff;

   logic [MEM_W-1:0]  mem [NUM_BINS];
   logic [MEM_W-1:0]  rd_ff;

   logic [BIN_W-1:0]  out_bin_ff;
   logic [VAL_W-1:0]  out_value_ff;
   logic [VAL_W-1:0]  out_order_ff;
   logic              out_filled_ff;

   logic [HALF_W-1:0] mul_a, mul_b;
   logic [VAL_W-1:0]  mul_p;

   logic              bin_ok, mode_ok, is_merge, is_clear, applied, first_take;
   logic              old_used, new_used, item_we, mem_wr;
   logic [VAL_W-1:0]  old_accum, old_order, cur, folded, new_accum, new_order, ident;
   logic [BIN_AW-1:0] bin_addr, wr_addr;
   logic [MEM_W-1:0]  wr_data;

   // Configuration and control counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_COUNT;
         exp_ff     <= EXP_W'(1);
         clr_cnt_ff <= '0;
         exp_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_AGG_MODE:  mode_ff <= csr_wdata[MODE_W-1:0];
               CSR_POWER_EXP: exp_ff  <= csr_wdata[EXP_W-1:0];
               default:       mode_ff <= mode_ff;
            endcase
         end
         if (ctl_cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + BIN_AW'(1);
         end
         if (ctl_cmd.load_item) begin
            exp_cnt_ff <= exp_ff;
         end else if (ctl_cmd.mul_op == MUL_FINISH) begin
            exp_cnt_ff <= exp_cnt_ff - EXP_W'(1);
         end
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (ctl_cmd.load_item) begin
         cmd_ff <= cmd_type'(req_tuser[CMD_W-1:0]);
         inc_ff <= req_tuser[CMD_W];
         bin_ff <= req_tdata[BIN_W-1:0];
         val_ff <= req_tdata[BIN_W +: VAL_W];
         key_ff <= req_tdata[BIN_W+VAL_W +: VAL_W];
      end
   end

   // Shared 32x32 multiplier; a 64-bit product modulo 2^64 takes four steps.
   always_comb begin
      mul_a = (ctl_cmd.mul_op == MUL_HL) ? pow_ff[VAL_W-1:HALF_W] : pow_ff[HALF_W-1:0];
      mul_b = (ctl_cmd.mul_op == MUL_LH) ? val_ff[VAL_W-1:HALF_W] : val_ff[HALF_W-1:0];
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_item) begin
         pow_ff <= VAL_W'(1);
      end else begin
         unique case (ctl_cmd.mul_op)
            MUL_LL: begin
               prod_ff <= mul_p;
            end
            MUL_HL: begin
               prod_ff <= mul_p;
               part_ff <= prod_ff;
            end
            MUL_LH: begin
               prod_ff <= mul_p;
               part_ff[VAL_W-1:HALF_W] <= part_ff[VAL_W-1:HALF_W] + prod_ff[HALF_W-1:0];
            end
            MUL_FINISH: begin
               pow_ff <= {part_ff[VAL_W-1:HALF_W] + prod_ff[HALF_W-1:0],
                          part_ff[HALF_W-1:0]};
            end
            default: begin
               pow_ff <= pow_ff;
            end
         endcase
      end
   end

   // Fold of the item into the bin that was read.
   always_comb begin
      bin_ok   = (32'(bin_ff) < NUM_BINS);
      mode_ok  = (mode_ff <= MODE_FIRST);
      is_merge = (cmd_ff == CMD_MERGE);
      is_clear = (cmd_ff == CMD_CLEAR);
      applied  = bin_ok && mode_ok && (is_merge || ((cmd_ff == CMD_SAMPLE) && inc_ff));
      ident    = identity_of(mode_ff);

      old_used  = rd_ff[MEM_W-1];
      old_accum = rd_ff[VAL_W-1:0];
      // An empty bin always holds the largest key, whatever the memory says.
      old_order = old_used ? rd_ff[2*VAL_W-1:VAL_W] : S64_MAX;
      cur       = old_used ? old_accum : ident;

      first_take = ($signed(key_ff) < $signed(old_order));

      unique case (mode_ff)
         MODE_COUNT: folded = cur + (is_merge ? val_ff : VAL_W'(1));
         MODE_MIN:   folded = ($signed(val_ff) < $signed(cur)) ? val_ff : cur;
         MODE_MAX:   folded = ($signed(cur) < $signed(val_ff)) ? val_ff : cur;
         MODE_SUM:   folded = cur + val_ff;
         MODE_POWER: folded = cur + (is_merge ? val_ff : pow_ff);
         MODE_FIRST: folded = first_take ? val_ff : cur;
         default:    folded = cur;
      endcase

      new_accum = applied ? folded : old_accum;
      new_used  = is_clear ? 1'b0 : (applied || old_used);
      if (is_clear) begin
         new_order = S64_MAX;
      end else if (applied && (mode_ff == MODE_FIRST) && first_take) begin
         new_order = key_ff;
      end else begin
         new_order = old_order;
      end

      item_we  = ctl_cmd.mem_we && bin_ok && (applied || is_clear);
      bin_addr = BIN_AW'(bin_ff);
      mem_wr   = ctl_cmd.clr_step || item_we;
      wr_addr  = ctl_cmd.clr_step ? clr_cnt_ff : bin_addr;
      wr_data  = ctl_cmd.clr_step ? {1'b0, S64_MAX, {VAL_W{1'b0}}}
                                  : {new_used, new_order, new_accum};
   end

   // Bin memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl_cmd.mem_rd) begin
         rd_ff <= mem[bin_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.out_load) begin
         out_bin_ff    <= bin_ff;
         out_filled_ff <= bin_ok && new_used;
         out_value_ff  <= (bin_ok && new_used) ? new_accum : ident;
         out_order_ff  <= (bin_ok && new_used) ? new_order : S64_MAX;
      end
   end

   assign status.clr_last = (clr_cnt_ff == BIN_AW'(NUM_BINS - 1));
   assign status.need_pow = (cmd_ff == CMD_SAMPLE) && inc_ff && (mode_ff == MODE_POWER);
   assign status.exp_zero = (exp_cnt_ff == '0);
   assign status.exp_last = (exp_cnt_ff == EXP_W'(1));

   assign rsp_tdata = {{PAD_W{1'b0}}, out_order_ff, out_value_ff, out_bin_ff};
   assign rsp_tuser = out_filled_ff;

endmodule

>>> rtl/core/grid_bin_aggregator.sv
// Grid bin aggregator: per-bin count, min, max, sum, sum of powers or first-by-order.
//
// Request channel (req_*): one transaction per command. tuser carries the command
// (sample, merge, read, clear) and the include flag; tdata carries bin index,
// value and order key. Every request yields exactly one response on rsp_*, holding
// the addressed bin after the command: bin, aggregate, order key, and in tuser the
// filled flag. The csr_* port writes the mode and the power exponent; the user is to
// write them only while idle, which the block itself does not enforce. One request
// is in work at a time: an accepted request passes through a bin read and a bin
// write, which loads the response register, and only then is the next request
// accepted. An included sample in sum-of-powers mode runs the shared 32x32
// multiplier in between, once per unit of the exponent; it builds each 64-bit
// product in four steps. A finished response waits in its output register; if the
// receiver stalls, the next request is still accepted and worked up to its bin
// write, which waits for the register to free. After reset a clearing pass marks
// every bin empty; no request is accepted during it, configuration writes are.
// Depends on gba_pkg, gba_ctrl and gba_datapath.
module grid_bin_aggregator
   import gba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,  // bin_index, sample_value, order_key, pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // cmd, include_req
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,  // out_bin, bin_value, bin_order, pad
   output logic [RSP_USER_W-1:0] rsp_tuser   // bin_filled
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type status;

   gba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .ctl_cmd    (ctl_cmd)
   );

   gba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .ctl_cmd   (ctl_cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> tb/grid_bin_checker.sv
// Checker for the grid bin aggregator: watches the register port and both streams,
// predicts every response from its own copy of the bins and compares field by field.
// Depends on gba_pkg for widths, command codes, mode codes and register indexes.
module grid_bin_checker
   import gba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,  // bin_index, sample_value, order_key, pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // cmd, include_req
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_W-1:0]     rsp_tdata,  // out_bin, bin_value, bin_order, pad
   input  logic [RSP_USER_W-1:0] rsp_tuser,  // bin_filled
   output int                    error_count,
   output int                    outstanding,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] order;
      logic             filled;
   } bin_result_type;

   logic [MODE_W-1:0] shadow_mode;
   logic [EXP_W-1:0]  shadow_exp;
   logic [VAL_W-1:0]  accum_mem [NUM_BINS];
   logic [VAL_W-1:0]  order_mem [NUM_BINS];
   logic              used_mem  [NUM_BINS];
   bin_result_type    bin_result_queue [$];

   initial begin
      error_count   = 0;
      outstanding   = 0;
      checked_count = 0;
   end

   function automatic logic [VAL_W-1:0] empty_value(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_MIN: return S64_MAX;
         MODE_MAX: return S64_MIN;
         default:  return '0;
      endcase
   endfunction

   function automatic void fold_into_bin(input logic [BIN_W-1:0] bin,
                                         input logic [VAL_W-1:0] val,
                                         input logic [VAL_W-1:0] key,
                                         input logic is_merge);
      logic [VAL_W-1:0] acc;
      logic [VAL_W-1:0] term;
      int               k;
      acc = used_mem[bin] ? accum_mem[bin] : empty_value(shadow_mode);
      case (shadow_mode)
         MODE_COUNT: acc = acc + (is_merge ? val : 64'd1);
         MODE_MIN:   if ($signed(val) < $signed(acc)) acc = val;
         MODE_MAX:   if ($signed(acc) < $signed(val)) acc = val;
         MODE_SUM:   acc = acc + val;
         MODE_POWER: begin
            term = 64'd1;
            if (!is_merge) begin
               for (k = 0; k < shadow_exp; k++) term = term * val;
            end
            acc = acc + (is_merge ? val : term);
         end
         MODE_FIRST: begin
            // Only a strictly smaller key takes over the bin.
            if ($signed(key) < $signed(order_mem[bin])) begin
               acc = val;
               order_mem[bin] = key;
            end
         end
         default: return;  // unused mode codes leave the bin alone
      endcase
      accum_mem[bin] = acc;
      used_mem[bin]  = 1'b1;
   endfunction

   function automatic bin_result_type apply_request(input cmd_type cmd,
                                                    input logic [BIN_W-1:0] bin,
                                                    input logic [VAL_W-1:0] val,
                                                    input logic [VAL_W-1:0] key,
                                                    input logic incl);
      bin_result_type r;
      if ((cmd == CMD_SAMPLE && incl) || cmd == CMD_MERGE) begin
         fold_into_bin(bin, val, key, cmd == CMD_MERGE);
      end else if (cmd == CMD_CLEAR) begin
         accum_mem[bin] = '0;
         order_mem[bin] = S64_MAX;
         used_mem[bin]  = 1'b0;
      end
      r.bin = bin;
      if (used_mem[bin]) begin
         r.value  = accum_mem[bin];
         r.order  = order_mem[bin];
         r.filled = 1'b1;
      end else begin
         r.value  = empty_value(shadow_mode);
         r.order  = S64_MAX;
         r.filled = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bin_result_type exp_r;
      bin_result_type act_r;
      if (reset) begin
         shadow_mode = MODE_COUNT;
         shadow_exp  = 4'd1;
         for (int i = 0; i < NUM_BINS; i++) begin
            accum_mem[i] = '0;
            order_mem[i] = S64_MAX;
            used_mem[i]  = 1'b0;
         end
         bin_result_queue.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_AGG_MODE) shadow_mode = csr_wdata[MODE_W-1:0];
            else shadow_exp = csr_wdata[EXP_W-1:0];
         end
         // Responses are matched before a request of the same edge is queued.
         if (rsp_tvalid && rsp_tready) begin
            act_r.bin    = rsp_tdata[BIN_W-1:0];
            act_r.value  = rsp_tdata[BIN_W +: VAL_W];
            act_r.order  = rsp_tdata[BIN_W+VAL_W +: VAL_W];
            act_r.filled = rsp_tuser[0];
            checked_count = checked_count + 1;
            if (bin_result_queue.size() == 0) begin
               $error("Response for bin %0d arrived with no request waiting", act_r.bin);
               error_count = error_count + 1;
            end else begin
               exp_r = bin_result_queue.pop_front();
               if (act_r.bin !== exp_r.bin) begin
                  $error("out_bin mismatch: expected %0d, actual %0d", exp_r.bin, act_r.bin);
                  error_count = error_count + 1;
               end
               if (act_r.value !== exp_r.value) begin
                  $error("bin_value mismatch: expected %h, actual %h", exp_r.value,
                         act_r.value);
                  error_count = error_count + 1;
               end
               if (act_r.order !== exp_r.order) begin
                  $error("bin_order mismatch: expected %h, actual %h", exp_r.order,
                         act_r.order);
                  error_count = error_count + 1;
               end
               if (act_r.filled !== exp_r.filled) begin
                  $error("bin_filled mismatch: expected %0b, actual %0b", exp_r.filled,
                         act_r.filled);
                  error_count = error_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bin_result_queue.push_back(apply_request(cmd_type'(req_tuser[CMD_W-1:0]),
                                                     req_tdata[BIN_W-1:0],
                                                     req_tdata[BIN_W +: VAL_W],
                                                     req_tdata[BIN_W+VAL_W +: VAL_W],
                                                     req_tuser[CMD_W]));
         end
         outstanding <= bin_result_queue.size();
      end
   end

endmodule

>>> tb/grid_bin_aggregator_test.sv
// Top of the grid bin aggregator testbench: clock, reset, register writes, request
// stimulus, response back-pressure, watchdog and verdict.
// Depends on gba_pkg, the grid_bin_aggregator RTL and grid_bin_checker.
module grid_bin_aggregator_test
   import gba_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
   localparam int STALL_LIMIT   = 4000;
   localparam int SEGMENTS      = 12;
   localparam int SEG_REQUESTS  = 95;
   localparam int SETTLE_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int error_count;
   int outstanding;
   int checked_count;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int sent_count    = 0;
   int config_count  = 0;
   int stall_cycles  = 0;

   // Register setting of each random segment; spare mode codes are included.
   logic [MODE_W-1:0] seg_mode [SEGMENTS] = '{MODE_SUM, MODE_POWER, MODE_FIRST, MODE_MIN,
                                              MODE_MAX, MODE_COUNT, MODE_POWER, MODE_SPARE_6,
                                              MODE_FIRST, MODE_SUM, MODE_POWER, MODE_SPARE_7};
   logic [EXP_W-1:0]  seg_exp  [SEGMENTS] = '{4'd8, 4'd0, 4'd3, 4'd1, 4'd8, 4'd2,
                                              4'd8, 4'd5, 4'd0, 4'd7, 4'd1, 4'd4};

   always #6 clock = ~clock;

   grid_bin_aggregator u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   grid_bin_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic send_request(input cmd_type cmd, input logic [BIN_W-1:0] bin,
                               input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] key,
                               input logic incl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, key, val, bin};
      req_tuser  <= {incl, cmd};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Holds the request stream until every queued response has been seen.
   task automatic drain_responses;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic load_config(input logic [MODE_W-1:0] mode, input logic [EXP_W-1:0] expo);
      csr_we    <= 1'b1;
      csr_index <= CSR_AGG_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_index <= CSR_POWER_EXP;
      csr_wdata <= expo;
      @(posedge clock);
      csr_we <= 1'b0;
      config_count++;
   endtask

   function automatic logic [VAL_W-1:0] pick_value(input int small_pct);
      int     r;
      longint s;
      r = $urandom_range(99);
      if (r < small_pct) begin
         s = longint'($urandom_range(16)) - 8;
         return s;
      end else if (r < small_pct + 12) begin
         case ($urandom_range(3))
            0:       return S64_MAX;
            1:       return S64_MIN;
            2:       return '0;
            default: return '1;
         endcase
      end
      return {$urandom, $urandom};
   endfunction

   task automatic send_random_request;
      cmd_type          cmd;
      logic [BIN_W-1:0] bin;
      int               r;
      r = $urandom_range(99);
      if (r < 55)      cmd = CMD_SAMPLE;
      else if (r < 75) cmd = CMD_MERGE;
      else if (r < 88) cmd = CMD_READ;
      else             cmd = CMD_CLEAR;
      // Most traffic hits a few bins at both ends so that they build up history.
      if ($urandom_range(99) < 75) begin
         bin = ($urandom_range(1) ? 10'd0 : 10'd1016) + BIN_W'($urandom_range(7));
      end else begin
         bin = BIN_W'($urandom_range(NUM_BINS - 1));
      end
      send_request(cmd, bin, pick_value(40), pick_value(50), $urandom_range(9) != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 33;
      rsp_idle_pct  = 76;

      // Directed part: wrap-around, masked samples, merge ignoring the include flag,
      // clears, key ties in first mode, mode changes, a spare mode and exponents 0 and 8.
      load_config(MODE_SUM, 4'd1);
      send_request(CMD_READ,   10'd0,    '0,      '0,      1'b1);
      send_request(CMD_SAMPLE, 10'd0,    S64_MAX, '0,      1'b1);
      send_request(CMD_SAMPLE, 10'd0,    64'd1,   '0,      1'b1);
      send_request(CMD_SAMPLE, 10'd1023, S64_MIN, S64_MIN, 1'b0);
      send_request(CMD_MERGE,  10'd1023, '1,      S64_MAX, 1'b0);
      send_request(CMD_CLEAR,  10'd1023, '1,      '1,      1'b1);
      send_request(CMD_READ,   10'd1023, '0,      '0,      1'b0);
      drain_responses();
      load_config(MODE_FIRST, 4'd1);
      send_request(CMD_SAMPLE, 10'd5, 64'd10, 64'd100, 1'b1);
      send_request(CMD_SAMPLE, 10'd5, 64'd20, 64'd100, 1'b1);
      send_request(CMD_SAMPLE, 10'd5, 64'd30, S64_MIN, 1'b1);
      send_request(CMD_SAMPLE, 10'd5, 64'd40, -64'sd5, 1'b0);
      send_request(CMD_MERGE,  10'd5, 64'd50, S64_MAX, 1'b1);
      drain_responses();
      load_config(MODE_MIN, 4'd1);
      send_request(CMD_READ,   10'd0, '0,      '0, 1'b1);
      send_request(CMD_READ,   10'd7, '0,      '0, 1'b1);
      send_request(CMD_SAMPLE, 10'd7, S64_MIN, '0, 1'b1);
      drain_responses();
      load_config(MODE_MAX, 4'd1);
      send_request(CMD_SAMPLE, 10'd8, S64_MIN, '0, 1'b1);
      drain_responses();
      load_config(MODE_COUNT, 4'd1);
      send_request(CMD_SAMPLE, 10'd9, 64'd123,  '0, 1'b1);
      send_request(CMD_MERGE,  10'd9, -64'sd2,  '0, 1'b0);
      drain_responses();
      load_config(MODE_SPARE_7, 4'd1);
      send_request(CMD_SAMPLE, 10'd9,  64'd5, '0, 1'b1);
      send_request(CMD_MERGE,  10'd9,  64'd5, '0, 1'b1);
      send_request(CMD_READ,   10'd10, '0,    '0, 1'b1);
      drain_responses();
      load_config(MODE_POWER, 4'd0);
      send_request(CMD_SAMPLE, 10'd11, 64'd123, '0, 1'b1);
      drain_responses();
      load_config(MODE_POWER, 4'd8);
      send_request(CMD_SAMPLE, 10'd11, 64'd3,   '0, 1'b1);
      send_request(CMD_SAMPLE, 10'd11, '1,      '0, 1'b1);
      send_request(CMD_MERGE,  10'd11, S64_MIN, '0, 1'b1);

      // Random part: three idle profiles, four register settings each.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_responses();
         case (seg / 4)
            0: begin
               send_idle_pct = 33;
               rsp_idle_pct  = 76;
            end
            1: begin
               send_idle_pct = 76;
               rsp_idle_pct  = 33;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         load_config(seg_mode[seg], seg_exp[seg]);
         for (int n = 0; n < SEG_REQUESTS; n++) send_random_request();
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outstanding != 0) $error("%0d responses never arrived", outstanding);
      $display("Summary: %0d requests over %0d register settings (all modes, spare codes,",
               sent_count, config_count);
      $display("exponents 0 to 8, three idle profiles); %0d responses compared.",
               checked_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/gba_pkg.sv
rtl/core/gba_ctrl.sv
rtl/core/gba_datapath.sv
rtl/core/grid_bin_aggregator.sv
tb/grid_bin_checker.sv
tb/grid_bin_aggregator_test.sv
